// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE      = 16'hDC00;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] word;
      logic [1:0]  status;
      logic        run_last;
      logic        string_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

// ===== src/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode; produces up to two results per transfer.
// ----------------------------------------------------------------------------
module u8u16_decode
   import u8u16_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      in_byte,
   input  logic            string_last,
   output result_pair_type results
);

   logic [1:0]  remaining_ff, remaining_in;
   logic [1:0]  seq_length_ff, seq_length_in;
   logic [20:0] code_accum_ff, code_accum_in;
   logic        first_cont_ff, first_cont_in;
   logic        held_invalid_ff, held_invalid_in;
   logic        discarding_ff, discarding_in;

   logic [1:0]  n;
   logic [15:0] word0, word1;
   logic [1:0]  status0;
   logic [1:0]  expect_len;
   logic [4:0]  lead;
   logic        fault;
   logic [20:0] accum_next;
   logic [20:0] offset;
   logic [1:0]  remaining_dec;

   always_comb begin
      remaining_in    = remaining_ff;
      seq_length_in   = seq_length_ff;
      code_accum_in   = code_accum_ff;
      first_cont_in   = first_cont_ff;
      held_invalid_in = held_invalid_ff;
      discarding_in   = discarding_ff;
      n               = 2'd0;
      word0           = '0;
      word1           = '0;
      status0         = STATUS_OK;
      expect_len      = 2'd0;
      lead            = '0;
      fault           = held_invalid_ff;
      accum_next      = {code_accum_ff[14:0], in_byte[5:0]};
      offset          = accum_next - SUPPLEMENTARY_BASE;
      remaining_dec   = remaining_ff - 2'd1;

      if (discarding_ff) begin
         if (string_last) begin
            discarding_in   = 1'b0;
            remaining_in    = '0;
            seq_length_in   = '0;
            code_accum_in   = '0;
            first_cont_in   = 1'b0;
            held_invalid_in = 1'b0;
         end
      end else if (remaining_ff == 2'd0) begin
         if (!in_byte[7]) begin
            n     = 2'd1;
            word0 = {8'h00, in_byte};
         end else if (in_byte[7:6] != 2'b11 || in_byte[7:3] == 5'b11111) begin
            n               = 2'd1;
            status0         = STATUS_INVALID;
            remaining_in    = '0;
            seq_length_in   = '0;
            code_accum_in   = '0;
            first_cont_in   = 1'b0;
            held_invalid_in = 1'b0;
            discarding_in   = !string_last;
         end else begin
            priority if (!in_byte[5]) begin
               expect_len = 2'd1;
               lead       = in_byte[4:0];
            end else if (!in_byte[4]) begin
               expect_len = 2'd2;
               lead       = {1'b0, in_byte[3:0]};
            end else begin
               expect_len = 2'd3;
               lead       = {2'b00, in_byte[2:0]};
            end
            held_invalid_in = (expect_len == 2'd1 && lead[4:1] == 4'd0) ||
                              (expect_len == 2'd3 && lead > 5'd4);
            seq_length_in   = expect_len;
            remaining_in    = expect_len;
            code_accum_in   = {16'd0, lead};
            first_cont_in   = (expect_len >= 2'd2);
            if (string_last) begin
               n               = 2'd1;
               status0         = STATUS_TRUNCATED;
               remaining_in    = '0;
               seq_length_in   = '0;
               code_accum_in   = '0;
               first_cont_in   = 1'b0;
               held_invalid_in = 1'b0;
            end
         end
      end else begin
         fault = held_invalid_ff || (in_byte[7:6] != 2'b10);
         if (first_cont_ff) begin
            unique case (seq_length_ff)
               2'd2: begin
                  fault = fault ||
                          (code_accum_ff == 21'd0 && !in_byte[5]) ||
                          (code_accum_ff == 21'd13 && in_byte[5]);
               end
               2'd3: begin
                  fault = fault ||
                          (code_accum_ff == 21'd0 && in_byte[5:4] == 2'b00) ||
                          (code_accum_ff == 21'd4 && in_byte[5:4] != 2'b00);
               end
               default: begin
               end
            endcase
         end
         first_cont_in   = 1'b0;
         held_invalid_in = fault;
         code_accum_in   = accum_next;
         remaining_in    = remaining_dec;
         if (remaining_dec == 2'd0) begin
            if (fault) begin
               n             = 2'd1;
               status0       = STATUS_INVALID;
               discarding_in = !string_last;
            end else if (accum_next < SUPPLEMENTARY_BASE) begin
               n     = 2'd1;
               word0 = accum_next[15:0];
            end else begin
               n     = 2'd2;
               word0 = HIGH_SURROGATE | {6'd0, offset[19:10]};
               word1 = LOW_SURROGATE | {6'd0, offset[9:0]};
            end
            remaining_in    = '0;
            seq_length_in   = '0;
            code_accum_in   = '0;
            held_invalid_in = 1'b0;
         end else if (string_last) begin
            n               = 2'd1;
            status0         = STATUS_TRUNCATED;
            remaining_in    = '0;
            seq_length_in   = '0;
            code_accum_in   = '0;
            held_invalid_in = 1'b0;
         end
      end
   end

   always_comb begin
      results.count             = take ? n : 2'd0;
      results.first.word        = word0;
      results.first.status      = status0;
      results.first.run_last    = (n == 2'd1);
      results.first.string_end  = (n == 2'd1) && string_last;
      results.second.word       = word1;
      results.second.status     = STATUS_OK;
      results.second.run_last   = 1'b1;
      results.second.string_end = string_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff    <= '0;
         seq_length_ff   <= '0;
         code_accum_ff   <= '0;
         first_cont_ff   <= 1'b0;
         held_invalid_ff <= 1'b0;
         discarding_ff   <= 1'b0;
      end else if (take) begin
         remaining_ff    <= remaining_in;
         seq_length_ff   <= seq_length_in;
         code_accum_ff   <= code_accum_in;
         first_cont_ff   <= first_cont_in;
         held_invalid_ff <= held_invalid_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

// ===== src/u8u16_result_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_result_queue
// Four-entry result queue; takes up to two results, gives one per cycle on out_ready.
// ----------------------------------------------------------------------------
module u8u16_result_queue
   import u8u16_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_pair_type push,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_result
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic                   pop;

   assign out_valid  = (count_ff != '0);
   assign out_result = entry_ff[rd_ptr_ff];
   assign room       = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign pop        = out_valid && out_ready;
   assign wr_next    = wr_ptr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== src/utf8_to_utf16_decoder.sv =====
// A result enters the result queue when its byte is taken and is offered from
// its head. Throughput: one byte per cycle while the queue has room; a byte that
// completes a character above U+FFFF gives two words, the output drains one word
// per cycle while the sink is ready, and so the four-entry queue sets the rate.
// Reset: synchronous, clears the sequence state and empties the result queue.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 transcoder with error reporting and backpressure.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // string_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] word
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] run_last
   output logic        rsp_tlast    // string_end
);

   result_pair_type pair;
   result_type      head;
   logic            take;

   assign take = req_tvalid && req_tready;

   u8u16_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_tdata),
      .string_last (req_tlast),
      .results     (pair)
   );

   u8u16_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (pair),
      .room       (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (head)
   );

   assign rsp_tdata = head.word;
   assign rsp_tuser = {head.run_last, head.status};
   assign rsp_tlast = head.string_end;

endmodule
